[rtl/cpmm_pkg.sv]
package cpmm_pkg;

   // Field widths fixed by the item formats
   localparam int LOAD_W  = 16;
   localparam int TOT_W   = 26;
   localparam int PARTS_W = 11;

   // Width of the binary search bounds: one above the largest total
   localparam int BOUND_W = TOT_W + 1;

   localparam logic [PARTS_W-1:0] PARTS_RESET = PARTS_W'(1);

   // Search engine states
   typedef enum logic [3:0] {
      SRCH_IDLE = 4'b0001,
      SRCH_PASS = 4'b0010,
      SRCH_SCAN = 4'b0100,
      SRCH_DONE = 4'b1000
   } srch_state_type;

endpackage

[rtl/cpmm_req_if.sv]
interface cpmm_req_if;
   logic                         valid;
   logic                         ready;
   logic [cpmm_pkg::LOAD_W-1:0]  page_count;
   logic                         last;

   modport source (output valid, page_count, last, input ready);
   modport sink   (input valid, page_count, last, output ready);
endinterface

[rtl/cpmm_rsp_if.sv]
interface cpmm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cpmm_pkg::TOT_W-1:0]   max_load;
   logic                         feasible;

   modport source (output valid, max_load, feasible, input ready);
   modport sink   (input valid, max_load, feasible, output ready);
endinterface

[rtl/cpmm_ram.sv]
module cpmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cpmm_fifo.sv]
module cpmm_fifo #(
   parameter int WIDTH = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   // Two-entry job queue
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

endmodule

[rtl/cpmm_front.sv]
module cpmm_front #(
   parameter int MAX_ELEMENTS = 1024,
   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int JOB_W = 1 + CNT_W + cpmm_pkg::TOT_W + cpmm_pkg::PARTS_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   cpmm_req_if.sink                      req_bus,
   input  logic [cpmm_pkg::PARTS_W-1:0]  parts,
   output logic                          ram_wr_en,
   output logic [IDX_W:0]                ram_wr_addr,
   output logic [cpmm_pkg::LOAD_W-1:0]   ram_wr_data,
   output logic                          job_push,
   output logic [JOB_W-1:0]              job_data,
   input  logic                          job_done
);
   import cpmm_pkg::*;

   typedef struct packed {
      logic               bank;
      logic [CNT_W-1:0]   count;
      logic [TOT_W-1:0]   total;
      logic [PARTS_W-1:0] parts;
      logic               skip;
   } job_type;

   logic             bank_ff,  bank_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [1:0]       jobs_ff,  jobs_in;

   logic             transfer;
   logic             room;
   logic [CNT_W-1:0] cnt_next;
   logic [TOT_W-1:0] total_next;
   job_type          job;

   // Both banks held by unfinished sequences: hold off the source
   assign req_bus.ready = (jobs_ff != 2'd2);
   assign transfer      = req_bus.valid && req_bus.ready;

   // Drop elements once the bank is full
   assign room       = (cnt_ff < CNT_W'(MAX_ELEMENTS));
   assign cnt_next   = room ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign total_next = room ? total_ff + TOT_W'(req_bus.page_count) : total_ff;

   assign ram_wr_en   = transfer && room;
   assign ram_wr_addr = {bank_ff, cnt_ff[IDX_W-1:0]};
   assign ram_wr_data = req_bus.page_count;

   // Describe the finished sequence for the search engine
   always_comb begin
      job.bank  = bank_ff;
      job.count = cnt_next;
      job.total = total_next;
      job.parts = parts;
      job.skip  = (parts == '0) || (32'(cnt_next) < 32'(parts));
   end

   assign job_push = transfer && req_bus.last;
   assign job_data = job;

   always_comb begin
      bank_in  = bank_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      if (transfer) begin
         if (req_bus.last) begin
            bank_in  = ~bank_ff;
            cnt_in   = '0;
            total_in = '0;
         end else begin
            cnt_in   = cnt_next;
            total_in = total_next;
         end
      end
   end

   // Count sequences handed over and not yet searched
   always_comb begin
      jobs_in = jobs_ff;
      if (job_push && !job_done) begin
         jobs_in = jobs_ff + 2'd1;
      end else if (job_done && !job_push) begin
         jobs_in = jobs_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         cnt_ff   <= '0;
         total_ff <= '0;
         jobs_ff  <= 2'd0;
      end else begin
         bank_ff  <= bank_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         jobs_ff  <= jobs_in;
      end
   end

endmodule

[rtl/cpmm_search.sv]
module cpmm_search #(
   parameter int MAX_ELEMENTS = 1024,
   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int JOB_W = 1 + CNT_W + cpmm_pkg::TOT_W + cpmm_pkg::PARTS_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  logic [JOB_W-1:0]              job_data,
   output logic                          job_pop,
   output logic                          job_done,
   output logic                          ram_rd_en,
   output logic [IDX_W:0]                ram_rd_addr,
   input  logic [cpmm_pkg::LOAD_W-1:0]   ram_rd_data,
   cpmm_rsp_if.source                    rsp_bus
);
   import cpmm_pkg::*;

   typedef struct packed {
      logic               bank;
      logic [CNT_W-1:0]   count;
      logic [TOT_W-1:0]   total;
      logic [PARTS_W-1:0] parts;
      logic               skip;
   } job_type;

   job_type job;

   srch_state_type   state_ff, state_in;

   logic               bank_ff,   bank_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [PARTS_W-1:0] parts_ff,  parts_in;
   logic [BOUND_W-1:0] lo_ff,     lo_in;
   logic [BOUND_W-1:0] hi1_ff,    hi1_in;
   logic [TOT_W-1:0]   mid_ff,    mid_in;
   logic [TOT_W-1:0]   best_ff,   best_in;
   logic               ok_ff,     ok_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               vld_ff,    vld_in;
   logic [TOT_W-1:0]   acc_ff,    acc_in;
   logic [CNT_W-1:0]   used_ff,   used_in;
   logic               fail_ff,   fail_in;

   logic               rsp_valid_ff,    rsp_valid_in;
   logic [TOT_W-1:0]   rsp_max_load_ff, rsp_max_load_in;
   logic               rsp_feasible_ff, rsp_feasible_in;

   logic               issue;
   logic [BOUND_W-1:0] sum;
   logic [BOUND_W-1:0] bound_sum;
   logic               fits;
   logic               out_free;

   assign job = job_type'(job_data);

   // Issue one read a cycle while the pass still has elements to fetch
   assign issue       = (state_ff == SRCH_SCAN) && (rd_idx_ff < count_ff);
   assign ram_rd_en   = issue;
   assign ram_rd_addr = {bank_ff, rd_idx_ff[IDX_W-1:0]};

   assign sum       = BOUND_W'(acc_ff) + BOUND_W'(ram_rd_data);
   assign bound_sum = lo_ff + hi1_ff - BOUND_W'(1);
   assign fits      = !fail_ff && (32'(used_ff) <= 32'(parts_ff));
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign job_pop  = (state_ff == SRCH_IDLE) && !job_empty;
   assign job_done = (state_ff == SRCH_DONE) && out_free;

   always_comb begin
      state_in        = state_ff;
      bank_in         = bank_ff;
      count_in        = count_ff;
      parts_in        = parts_ff;
      lo_in           = lo_ff;
      hi1_in          = hi1_ff;
      mid_in          = mid_ff;
      best_in         = best_ff;
      ok_in           = ok_ff;
      rd_idx_in       = rd_idx_ff;
      vld_in          = issue;
      acc_in          = acc_ff;
      used_in         = used_ff;
      fail_in         = fail_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_max_load_in = rsp_max_load_ff;
      rsp_feasible_in = rsp_feasible_ff;

      unique case (state_ff)
         // Take the next sequence; search bounds are [0, total]
         SRCH_IDLE: begin
            if (!job_empty) begin
               bank_in  = job.bank;
               count_in = job.count;
               parts_in = job.parts;
               lo_in    = '0;
               hi1_in   = BOUND_W'(job.total) + BOUND_W'(1);
               best_in  = '0;
               ok_in    = 1'b0;
               state_in = job.skip ? SRCH_DONE : SRCH_PASS;
            end
         end
         // Pick the trial cap, or finish when the range is empty
         SRCH_PASS: begin
            if (lo_ff < hi1_ff) begin
               mid_in    = bound_sum[BOUND_W-1:1];
               rd_idx_in = '0;
               acc_in    = '0;
               used_in   = CNT_W'(1);
               fail_in   = 1'b0;
               state_in  = SRCH_SCAN;
            end else begin
               state_in  = SRCH_DONE;
            end
         end
         // Greedy fill under the trial cap, one element a cycle
         SRCH_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               if (TOT_W'(ram_rd_data) > mid_ff) begin
                  fail_in = 1'b1;
               end else if (sum <= BOUND_W'(mid_ff)) begin
                  acc_in = sum[TOT_W-1:0];
               end else begin
                  used_in = used_ff + CNT_W'(1);
                  acc_in  = TOT_W'(ram_rd_data);
               end
            end
            // Pass complete: narrow the range
            if (!issue && !vld_ff) begin
               if (fits) begin
                  best_in = mid_ff;
                  ok_in   = 1'b1;
                  hi1_in  = BOUND_W'(mid_ff);
               end else begin
                  lo_in   = BOUND_W'(mid_ff) + BOUND_W'(1);
               end
               state_in = SRCH_PASS;
            end
         end
         // Hand the result to the output register
         SRCH_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_max_load_in = ok_ff ? best_ff : '0;
               rsp_feasible_in = ok_ff;
               state_in        = SRCH_IDLE;
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SRCH_IDLE;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff         <= bank_in;
      count_ff        <= count_in;
      parts_ff        <= parts_in;
      lo_ff           <= lo_in;
      hi1_ff          <= hi1_in;
      mid_ff          <= mid_in;
      best_ff         <= best_in;
      ok_ff           <= ok_in;
      rd_idx_ff       <= rd_idx_in;
      acc_ff          <= acc_in;
      used_ff         <= used_in;
      fail_ff         <= fail_in;
      rsp_max_load_ff <= rsp_max_load_in;
      rsp_feasible_ff <= rsp_feasible_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.max_load = rsp_max_load_ff;
   assign rsp_bus.feasible = rsp_feasible_ff;

endmodule

[rtl/contiguous_partition_min_max_load_top.sv]
// Splits a sequence of page counts into at most csr_wr_data contiguous parts and
// reports the smallest possible largest part sum. Page counts arrive one per
// transfer on req_bus and are stored in one of two RAM banks with a running
// total; the transfer marked last closes the sequence and hands it to the
// search engine through a two-entry job queue, so the next sequence can load
// into the other bank during the search. The engine binary-searches the cap
// over [0, total]: each trial picks the cap, then makes one greedy pass that
// reads the stored sequence through the single RAM read port at one element
// a cycle, then drains the read and closes the pass. A sequence takes at
// most 26 passes.
// Elements beyond MAX_ELEMENTS in one sequence are dropped. A sequence
// shorter than the part count, or a part count of zero, returns feasible = 0
// with max_load = 0. Write the part count only while the block is idle.
module contiguous_partition_min_max_load_top #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   cpmm_req_if.sink                      req_bus,
   cpmm_rsp_if.source                    rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [cpmm_pkg::PARTS_W-1:0]  csr_wr_data
);
   import cpmm_pkg::*;

   localparam int IDX_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int JOB_W     = 1 + CNT_W + TOT_W + PARTS_W + 1;
   localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

   logic [PARTS_W-1:0] parts_ff, parts_in;

   logic               ram_wr_en;
   logic [IDX_W:0]     ram_wr_addr;
   logic [LOAD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W:0]     ram_rd_addr;
   logic [LOAD_W-1:0]  ram_rd_data;

   logic               job_push;
   logic [JOB_W-1:0]   job_push_data;
   logic               job_pop;
   logic               job_empty;
   logic [JOB_W-1:0]   job_pop_data;
   logic               job_done;

   // Part count register
   assign parts_in = csr_wr_en ? csr_wr_data : parts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_ff <= PARTS_RESET;
      end else begin
         parts_ff <= parts_in;
      end
   end

   cpmm_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .parts       (parts_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job_push    (job_push),
      .job_data    (job_push_data),
      .job_done    (job_done)
   );

   cpmm_fifo #(
      .WIDTH (JOB_W)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_pop_data)
   );

   cpmm_ram #(
      .WIDTH (LOAD_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cpmm_search #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .job_empty   (job_empty),
      .job_data    (job_pop_data),
      .job_pop     (job_pop),
      .job_done    (job_done),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_bus     (rsp_bus)
   );

endmodule

[verif/tb_contiguous_partition_min_max_load_top.sv]
`timescale 1ns / 1ps

module tb_contiguous_partition_min_max_load_top;
   import cpmm_pkg::*;

   localparam int MAX_ELEMS     = 1024;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic [TOT_W-1:0] max_load;
      logic             feasible;
   } min_cap_type;

   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PERIODIC,
      RSP_BURSTY
   } rsp_pattern_type;

   typedef enum int {
      MIX_UNIFORM,
      MIX_SMALL,
      MIX_EXTREME,
      MIX_SPIKY
   } page_mix_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [PARTS_W-1:0] csr_wr_data;

   cpmm_req_if req_bus ();
   cpmm_rsp_if rsp_bus ();

   contiguous_partition_min_max_load_top #(
      .MAX_ELEMENTS (MAX_ELEMS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the block: held sequence, total and part count
   logic [LOAD_W-1:0]  held_pages [MAX_ELEMS];
   int unsigned        held_count = 0;
   logic [TOT_W-1:0]   held_total = '0;
   logic [PARTS_W-1:0] part_limit = PARTS_RESET;
   min_cap_type        pending_loads [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   bit          gapless     = 1'b0;

   // Greedy split: does the held sequence fit in part_limit parts under cap?
   function automatic bit fits_cap(input longint unsigned cap);
      longint unsigned acc;
      int unsigned     used;
      used = 1;
      acc  = 0;
      for (int i = 0; i < held_count; i++) begin
         if (held_pages[i] > cap)
            return 1'b0;
         if (acc + held_pages[i] <= cap) begin
            acc += held_pages[i];
         end else begin
            used++;
            acc = held_pages[i];
         end
      end
      return used <= part_limit;
   endfunction

   // Store one accepted page count; on last, search the minimal cap
   function automatic void absorb_page(input logic [LOAD_W-1:0] val, input logic lst);
      min_cap_type want;
      longint      lo;
      longint      hi;
      longint      mid;
      want = '0;
      if (held_count < MAX_ELEMS) begin
         held_pages[held_count] = val;
         held_count++;
         held_total += val;
      end
      if (!lst)
         return;
      if (part_limit != 0 && held_count >= part_limit) begin
         lo = 0;
         hi = held_total;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (fits_cap(mid)) begin
               want.max_load = mid[TOT_W-1:0];
               want.feasible = 1'b1;
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
      end
      pending_loads.push_back(want);
      held_count = 0;
      held_total = '0;
   endfunction

   // Send one page count, with random gaps between bursts
   task automatic send_page(input logic [LOAD_W-1:0] val, input logic lst);
      int unsigned gap;
      if (!gapless && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.page_count <= val;
      req_bus.last       <= lst;
      do @(posedge clock); while (!req_bus.ready);
      absorb_page(val, lst);
   endtask

   task automatic send_run(input logic [LOAD_W-1:0] vals [$]);
      foreach (vals[i])
         send_page(vals[i], i == vals.size() - 1);
   endtask

   // Hold the sender until every expected result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_loads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_parts(input logic [PARTS_W-1:0] val);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      part_limit = val;
   endtask

   function automatic logic [LOAD_W-1:0] pick_page(input page_mix_type mix);
      case (mix)
         MIX_SMALL:   return LOAD_W'($urandom_range(0, 15));
         MIX_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return LOAD_W'($urandom_range(0, 65535));
            endcase
         end
         MIX_SPIKY: begin
            if ($urandom_range(0, 7) == 0)
               return LOAD_W'($urandom_range(30000, 65535));
            return LOAD_W'($urandom_range(0, 300));
         end
         default:     return LOAD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Draw a sequence length, mostly near the part count
   function automatic int unsigned pick_length(input logic [PARTS_W-1:0] p);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (p == 0 || p > 100 || roll < 25)
         return $urandom_range(1, 30);
      if (roll < 85)
         return $urandom_range((p > 3) ? p - 3 : 1, p + 12);
      return $urandom_range(31, 160);
   endfunction

   // Receiver stall pattern
   rsp_pattern_type rsp_mode   = RSP_ALWAYS;
   int unsigned     mode_left  = 0;
   int unsigned     stall_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         rsp_mode  = rsp_pattern_type'($urandom_range(0, 3));
         mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (rsp_mode)
         RSP_ALWAYS:   rsp_bus.ready <= 1'b1;
         RSP_RANDOM:   rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         RSP_PERIODIC: rsp_bus.ready <= (cycle_count % 5 == 0);
         default: begin
            if (stall_left > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall_left = $urandom_range(5, 30);
            end
         end
      endcase
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_result
      min_cap_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_loads.size() == 0) begin
            $display("%0t: unexpected result: expected none, got max_load=%0d feasible=%0d",
                     $time, rsp_bus.max_load, rsp_bus.feasible);
            error_count++;
         end else begin
            want = pending_loads.pop_front();
            if (rsp_bus.max_load !== want.max_load) begin
               $display("%0t: max_load mismatch: expected %0d, got %0d",
                        $time, want.max_load, rsp_bus.max_load);
               error_count++;
            end
            if (rsp_bus.feasible !== want.feasible) begin
               $display("%0t: feasible mismatch: expected %0d, got %0d",
                        $time, want.feasible, rsp_bus.feasible);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[contiguous_partition_min_max_load_top] ERROR");
         $finish;
      end
   end

   // Single elements and a short run with the part count left at reset
   task automatic test_reset_parts();
      send_run('{16'd0});
      send_run('{16'hFFFF});
      send_run('{16'd3, 16'd9, 16'd4});
   endtask

   // Exact fit, then a sequence shorter than the part count
   task automatic test_exact_and_short();
      write_parts(3);
      send_run('{16'd5, 16'd1, 16'd7});
      send_run('{16'd2, 16'd2});
   endtask

   task automatic test_zero_loads();
      write_parts(2);
      send_run('{16'd0, 16'd0, 16'd0});
      send_run('{16'd10, 16'd20, 16'd30, 16'd40});
   endtask

   task automatic test_parts_zero();
      write_parts(0);
      send_run('{16'd8, 16'd8});
   endtask

   task automatic test_parts_extremes();
      write_parts(2047);
      send_run('{16'hFFFF});
      write_parts(1024);
      send_run('{16'd1, 16'd2});
   endtask

   // Fill the store with maximum loads, then drop two extra elements
   task automatic test_store_full();
      write_parts(1);
      for (int i = 0; i < MAX_ELEMS; i++)
         send_page(16'hFFFF, 1'b0);
      send_page(16'h1234, 1'b0);
      send_page(16'h0001, 1'b1);
   endtask

   // Random sequences over several part counts
   task automatic test_random_sequences();
      logic [PARTS_W-1:0] p;
      int unsigned        budget;
      int unsigned        sent;
      int unsigned        len;
      page_mix_type       mix;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       p = 1;
            1:       p = 2;
            2:       p = 3;
            3:       p = PARTS_W'($urandom_range(4, 12));
            4:       p = PARTS_W'($urandom_range(13, 40));
            5:       p = 0;
            6:       p = 2047;
            default: p = PARTS_W'($urandom_range(1, 6));
         endcase
         write_parts(p);
         gapless = (phase % 3 == 2);
         budget  = (p == 0 || p > 100) ? 20 : 36;
         sent    = 0;
         while (sent < budget) begin
            len = pick_length(p);
            mix = page_mix_type'($urandom_range(0, 3));
            for (int k = 0; k < len; k++)
               send_page(pick_page(mix), k == len - 1);
            sent += len;
            // pause the sender now and then until all results are back
            if ($urandom_range(0, 19) == 0)
               wait_drained();
         end
      end
      gapless = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.page_count = '0;
      req_bus.last       = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_parts();
      test_exact_and_short();
      test_zero_loads();
      test_parts_zero();
      test_parts_extremes();
      test_store_full();
      test_random_sequences();

      wait_drained();
      if (error_count == 0) begin
         $display("[contiguous_partition_min_max_load_top] OK");
      end else begin
         $display("[contiguous_partition_min_max_load_top] ERROR");
      end
      $finish;
   end

endmodule

[contiguous_partition_min_max_load_top.f]
rtl/cpmm_pkg.sv
rtl/cpmm_req_if.sv
rtl/cpmm_rsp_if.sv
rtl/cpmm_ram.sv
rtl/cpmm_fifo.sv
rtl/cpmm_front.sv
rtl/cpmm_search.sv
rtl/contiguous_partition_min_max_load_top.sv
verif/tb_contiguous_partition_min_max_load_top.sv
